// File: sv/pal_pkg.sv
// Shared constants and types for the positional array list core.
package pal_pkg;

    // Default list capacity and fixed field widths
    localparam int LIST_DEPTH_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int POS_W          = 7;
    localparam int IDX_W          = 6;
    localparam int STAT_W         = 3;
    localparam int ACT_W          = 2;

    // Action codes of an input item
    localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TRAVERSE = 2'd3;

    // Status codes of a result item
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

    // Port strobes from the sequencer to the element store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

// File: sv/positional_array_list_core.sv
// Top level of the positional array list: sequencer, count and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | to core   | i_in_valid / o_in_stall   | i_action, i_value, i_position
//   out     | from core | o_out_valid / i_out_stall | o_status, o_found_index,
//           |           |                           | o_item_value, o_list_count,
//           |           |                           | o_last_item
//
// One item at a time; the element store's single read and write port sets the pace.
// Insert moves the entries from the position upward one place up, then writes the value;
// delete moves the entries behind the position one place down; search reads from index 0
// until a match or the end; traverse emits one result per entry; rejects go straight out.
// Reset clears the count and the control state; the store keeps its contents.
// A stalled result holds the next result back, and the core waits with its input stalled.
module positional_array_list_core #(
    parameter int LIST_DEPTH = pal_pkg::LIST_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pal_pkg::ACT_W-1:0]         i_action,
    input  logic signed [pal_pkg::DATA_W-1:0] i_value,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pal_pkg::STAT_W-1:0]        o_status,
    output logic [pal_pkg::IDX_W-1:0]         o_found_index,
    output logic signed [pal_pkg::DATA_W-1:0] o_item_value,
    output logic [pal_pkg::POS_W-1:0]         o_list_count,
    output logic                              o_last_item
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [pal_pkg::POS_W-1:0] DEPTH_CNT = pal_pkg::POS_W'(LIST_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_SCAN  = 6'b000100,
        S_TRAV  = 6'b001000,
        S_TEMIT = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [pal_pkg::ACT_W-1:0]     r_act, n_act;
    logic [pal_pkg::DATA_W-1:0]    r_key, n_key;
    logic [pal_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [pal_pkg::POS_W-1:0]     r_idx, n_idx;
    logic [pal_pkg::POS_W-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]                 r_wa, n_wa;
    logic                          r_pend, n_pend;
    logic [pal_pkg::STAT_W-1:0]    r_stat, n_stat;
    logic [pal_pkg::IDX_W-1:0]     r_fidx, n_fidx;
    logic [pal_pkg::DATA_W-1:0]    r_oval, n_oval;

    logic                          r_out_valid, n_out_valid;
    logic [pal_pkg::STAT_W-1:0]    r_out_stat, n_out_stat;
    logic [pal_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [pal_pkg::DATA_W-1:0]    r_out_val, n_out_val;
    logic [pal_pkg::POS_W-1:0]     r_out_cnt, n_out_cnt;
    logic                          r_out_last, n_out_last;

    pal_pkg::t_ram_ctl             ram_ctl;
    logic [AW-1:0]                 wr_addr, rd_addr;
    logic [pal_pkg::DATA_W-1:0]    wr_data, rd_data;
    logic                          in_acc, out_free;
    logic [pal_pkg::POS_W-1:0]     idx_inc, idx_dec;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + 7'd1;
    assign idx_dec  = r_idx - 7'd1;

    pal_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequence the item through the store and load the result register
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_key       = r_key;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_wa        = r_wa;
        n_pend      = r_pend;
        n_stat      = r_stat;
        n_fidx      = r_fidx;
        n_oval      = r_oval;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_stat  = r_out_stat;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        ram_ctl     = '0;
        wr_addr     = r_wa;
        wr_data     = rd_data;
        rd_addr     = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act  = i_action;
                    n_key  = i_value;
                    n_pos  = i_position;
                    n_pend = 1'b0;
                    n_fidx = '0;
                    n_oval = '0;
                    n_stat = pal_pkg::ST_OK;
                    unique case (i_action)
                        pal_pkg::ACT_INSERT: begin
                            n_idx = r_cnt;
                            if (i_position > r_cnt) begin
                                n_stat  = pal_pkg::ST_BADPOS;
                                n_state = S_OUT;
                            end else if (r_cnt >= DEPTH_CNT) begin
                                n_stat  = pal_pkg::ST_FULL;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        pal_pkg::ACT_DELETE: begin
                            n_idx = i_position;
                            if (i_position >= r_cnt) begin
                                n_stat  = pal_pkg::ST_BADPOS;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        pal_pkg::ACT_SEARCH: begin
                            n_idx   = '0;
                            n_oval  = i_value;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_idx = '0;
                            if (r_cnt == '0) begin
                                n_stat  = pal_pkg::ST_EMPTY;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_TRAV;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Retire the entry read last cycle into its new place
                ram_ctl.wr_en = r_pend;
                if (r_act == pal_pkg::ACT_INSERT) begin
                    if (r_idx > r_pos) begin
                        ram_ctl.rd_en = 1'b1;
                        rd_addr       = idx_dec[AW-1:0];
                        n_wa          = r_idx[AW-1:0];
                        n_pend        = 1'b1;
                        n_idx         = idx_dec;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            ram_ctl.wr_en = 1'b1;
                            wr_addr       = r_pos[AW-1:0];
                            wr_data       = r_key;
                            n_cnt         = r_cnt + 7'd1;
                            n_state       = S_OUT;
                        end
                    end
                end else begin
                    if (idx_inc < r_cnt) begin
                        ram_ctl.rd_en = 1'b1;
                        rd_addr       = idx_inc[AW-1:0];
                        n_wa          = r_idx[AW-1:0];
                        n_pend        = 1'b1;
                        n_idx         = idx_inc;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_cnt   = r_cnt - 7'd1;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Compare the entry read last cycle, read the next one
                if (r_pend && (rd_data == r_key)) begin
                    n_stat  = pal_pkg::ST_OK;
                    n_fidx  = pal_pkg::IDX_W'(r_wa);
                    n_pend  = 1'b0;
                    n_state = S_OUT;
                end else if (r_idx < r_cnt) begin
                    ram_ctl.rd_en = 1'b1;
                    n_wa          = r_idx[AW-1:0];
                    n_pend        = 1'b1;
                    n_idx         = idx_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_stat  = pal_pkg::ST_MISS;
                        n_state = S_OUT;
                    end
                end
            end
            S_TRAV: begin
                ram_ctl.rd_en = 1'b1;
                n_wa          = r_idx[AW-1:0];
                n_idx         = idx_inc;
                n_state       = S_TEMIT;
            end
            S_TEMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = pal_pkg::ST_OK;
                    n_out_idx   = pal_pkg::IDX_W'(r_wa);
                    n_out_val   = rd_data;
                    n_out_cnt   = r_cnt;
                    n_out_last  = (r_idx == r_cnt);
                    n_state     = (r_idx == r_cnt) ? S_IDLE : S_TRAV;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = r_stat;
                    n_out_idx   = r_fidx;
                    n_out_val   = r_oval;
                    n_out_cnt   = r_cnt;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_wa       <= n_wa;
        r_stat     <= n_stat;
        r_fidx     <= n_fidx;
        r_oval     <= n_oval;
        r_out_stat <= n_out_stat;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_stat;
    assign o_found_index = r_out_idx;
    assign o_item_value  = r_out_val;
    assign o_list_count  = r_out_cnt;
    assign o_last_item   = r_out_last;

`ifndef SYNTHESIS
    // Count stays within capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_CNT)
        else $error("list count above capacity");

    // Count moves by at most one per item
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |->
            ((r_cnt == $past(r_cnt) + 7'd1) || (r_cnt == $past(r_cnt) - 7'd1)))
        else $error("list count jumped");

    // An accepted item always leaves idle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // The store is written only while shifting
    a_wr_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.wr_en |-> (r_state == S_SHIFT))
        else $error("store written outside a shift");
`endif

endmodule

// File: sv/pal_ram.sv
// Element store: one write port, one registered read port.
module pal_ram #(
    parameter int DEPTH = pal_pkg::LIST_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  pal_pkg::t_ram_ctl          i_ctl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [pal_pkg::DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [pal_pkg::DATA_W-1:0] o_rd_data
);

    logic [pal_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [pal_pkg::DATA_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
